// ===== design/i2cm_pkg.sv =====
package i2cm_pkg;

    localparam int BITS_PER_BYTE = 8;
    localparam int CFG_AW        = 2;
    localparam int CFG_DW        = 10;

    // command codes
    localparam logic [2:0] CMD_START    = 3'd0;
    localparam logic [2:0] CMD_STOP     = 3'd1;
    localparam logic [2:0] CMD_WRITE    = 3'd2;
    localparam logic [2:0] CMD_WAIT_ACK = 3'd3;
    localparam logic [2:0] CMD_READ     = 3'd4;

    // configuration register indexes
    localparam logic [CFG_AW-1:0] REG_START_STOP = 2'd0;
    localparam logic [CFG_AW-1:0] REG_BIT_PHASE  = 2'd1;
    localparam logic [CFG_AW-1:0] REG_SHORT      = 2'd2;
    localparam logic [CFG_AW-1:0] REG_ACK_TMO    = 2'd3;

    localparam logic [7:0] RST_START_STOP = 8'd4;
    localparam logic [7:0] RST_BIT_PHASE  = 8'd2;
    localparam logic [7:0] RST_SHORT      = 8'd1;
    localparam logic [9:0] RST_ACK_TMO    = 10'd250;

    typedef struct packed {
        logic       kind;
        logic [2:0] command;
        logic [7:0] tx_byte;
        logic       send_ack;
        logic       sda_in;
    } t_in_word;

    typedef struct packed {
        logic       scl_release;
        logic       sda_release;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       ack_fail;
        logic       command_ignored;
    } t_out_word;

    typedef struct packed {
        logic [7:0] start_stop_ticks;
        logic [7:0] bit_phase_ticks;
        logic [7:0] short_ticks;
        logic [9:0] ack_timeout;
    } t_cfg;

endpackage

// ===== design/i2cm_cfg_regs.sv =====
module i2cm_cfg_regs
    import i2cm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [CFG_AW-1:0] i_cfg_addr,
    input  logic [CFG_DW-1:0] i_cfg_data,
    output t_cfg              o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_stop_ticks <= RST_START_STOP;
            r_cfg.bit_phase_ticks  <= RST_BIT_PHASE;
            r_cfg.short_ticks      <= RST_SHORT;
            r_cfg.ack_timeout      <= RST_ACK_TMO;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_START_STOP: r_cfg.start_stop_ticks <= i_cfg_data[7:0];
                REG_BIT_PHASE:  r_cfg.bit_phase_ticks  <= i_cfg_data[7:0];
                REG_SHORT:      r_cfg.short_ticks      <= i_cfg_data[7:0];
                REG_ACK_TMO:    r_cfg.ack_timeout      <= i_cfg_data;
                default:        r_cfg                  <= r_cfg;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== design/i2cm_seq.sv =====
module i2cm_seq
    import i2cm_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_accept,
    input  t_in_word  i_word,
    input  t_cfg      i_cfg,
    output t_out_word o_result
);

    typedef enum logic [3:0] {
        S_IDLE, S_ST1, S_ST2, S_SP1, S_SP2, S_WSET, S_WHI, S_WLO,
        S_ASET1, S_ASET2, S_APOLL, S_RLO, S_RHI, S_KSET, S_KHI
    } t_state;

    localparam logic [3:0] BIT_LAST = 4'(BITS_PER_BYTE);

    t_state     r_state,  n_state;
    logic [7:0] r_hold,   n_hold;
    logic [3:0] r_bits,   n_bits;
    logic [7:0] r_shift,  n_shift;
    logic [9:0] r_poll,   n_poll;
    logic       r_scl,    n_scl;
    logic       r_sda,    n_sda;
    logic       r_ack,    n_ack;
    logic       r_fail,   n_fail;
    logic [7:0] r_rx,     n_rx;
    logic       done, ignored;

    always_comb begin
        n_state = r_state;
        n_hold  = r_hold;
        n_bits  = r_bits;
        n_shift = r_shift;
        n_poll  = r_poll;
        n_scl   = r_scl;
        n_sda   = r_sda;
        n_ack   = r_ack;
        n_fail  = r_fail;
        n_rx    = r_rx;
        done    = 1'b0;
        ignored = 1'b0;

        if (i_word.kind) begin
            if (r_state != S_IDLE || i_word.command > CMD_READ) begin
                ignored = 1'b1;
            end else begin
                case (i_word.command)
                    CMD_START: begin
                        n_scl   = 1'b1;
                        n_sda   = 1'b1;
                        n_state = S_ST1;
                        n_hold  = i_cfg.start_stop_ticks;
                    end
                    CMD_STOP: begin
                        n_scl   = 1'b0;
                        n_sda   = 1'b0;
                        n_state = S_SP1;
                        n_hold  = i_cfg.start_stop_ticks;
                    end
                    CMD_WRITE: begin
                        n_scl   = 1'b0;
                        n_bits  = '0;
                        n_sda   = i_word.tx_byte[7];
                        n_shift = {i_word.tx_byte[6:0], 1'b0};
                        n_state = S_WSET;
                        n_hold  = i_cfg.bit_phase_ticks;
                    end
                    CMD_WAIT_ACK: begin
                        n_fail  = 1'b0;
                        n_sda   = 1'b1;
                        n_state = S_ASET1;
                        n_hold  = i_cfg.short_ticks;
                    end
                    default: begin
                        n_scl   = 1'b0;
                        n_sda   = 1'b1;
                        n_bits  = '0;
                        n_shift = '0;
                        n_ack   = i_word.send_ack;
                        n_state = S_RLO;
                        n_hold  = i_cfg.bit_phase_ticks;
                    end
                endcase
            end
        end else if (r_state == S_APOLL) begin
            if (!i_word.sda_in) begin
                n_scl   = 1'b0;
                n_fail  = 1'b0;
                n_state = S_IDLE;
                done    = 1'b1;
            end else if (r_poll >= i_cfg.ack_timeout) begin
                // timed out: flag it and release the bus with a stop
                n_fail  = 1'b1;
                n_scl   = 1'b0;
                n_sda   = 1'b0;
                n_state = S_SP1;
                n_hold  = i_cfg.start_stop_ticks;
            end else begin
                n_poll = r_poll + 10'd1;
            end
        end else if (r_state != S_IDLE) begin
            if (r_hold > 8'd1) begin
                n_hold = r_hold - 8'd1;
            end else begin
                case (r_state)
                    S_ST1: begin
                        n_sda   = 1'b0;
                        n_state = S_ST2;
                        n_hold  = i_cfg.start_stop_ticks;
                    end
                    S_ST2: begin
                        n_scl   = 1'b0;
                        n_state = S_IDLE;
                        done    = 1'b1;
                    end
                    S_SP1: begin
                        n_scl   = 1'b1;
                        n_sda   = 1'b1;
                        n_state = S_SP2;
                        n_hold  = i_cfg.start_stop_ticks;
                    end
                    S_SP2: begin
                        n_state = S_IDLE;
                        done    = 1'b1;
                    end
                    S_WSET: begin
                        n_scl   = 1'b1;
                        n_state = S_WHI;
                        n_hold  = i_cfg.bit_phase_ticks;
                    end
                    S_WHI: begin
                        n_scl   = 1'b0;
                        n_state = S_WLO;
                        n_hold  = i_cfg.bit_phase_ticks;
                    end
                    S_WLO: begin
                        n_bits = r_bits + 4'd1;
                        if (n_bits >= BIT_LAST) begin
                            n_state = S_IDLE;
                            done    = 1'b1;
                        end else begin
                            n_sda   = r_shift[7];
                            n_shift = {r_shift[6:0], 1'b0};
                            n_state = S_WSET;
                            n_hold  = i_cfg.bit_phase_ticks;
                        end
                    end
                    S_ASET1: begin
                        n_scl   = 1'b1;
                        n_state = S_ASET2;
                        n_hold  = i_cfg.short_ticks;
                    end
                    S_ASET2: begin
                        n_state = S_APOLL;
                        n_poll  = '0;
                    end
                    S_RLO: begin
                        // sample on the rising clock edge
                        n_scl   = 1'b1;
                        n_shift = {r_shift[6:0], i_word.sda_in};
                        n_state = S_RHI;
                        n_hold  = i_cfg.short_ticks;
                    end
                    S_RHI: begin
                        n_scl  = 1'b0;
                        n_bits = r_bits + 4'd1;
                        n_hold = i_cfg.bit_phase_ticks;
                        if (n_bits >= BIT_LAST) begin
                            n_rx    = r_shift;
                            n_sda   = ~r_ack;
                            n_state = S_KSET;
                        end else begin
                            n_state = S_RLO;
                        end
                    end
                    S_KSET: begin
                        n_scl   = 1'b1;
                        n_state = S_KHI;
                        n_hold  = i_cfg.bit_phase_ticks;
                    end
                    S_KHI: begin
                        n_scl   = 1'b0;
                        n_state = S_IDLE;
                        done    = 1'b1;
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_hold  <= '0;
            r_bits  <= '0;
            r_shift <= '0;
            r_poll  <= '0;
            r_scl   <= 1'b1;
            r_sda   <= 1'b1;
            r_ack   <= 1'b0;
            r_fail  <= 1'b0;
            r_rx    <= '0;
        end else if (i_accept) begin
            r_state <= n_state;
            r_hold  <= n_hold;
            r_bits  <= n_bits;
            r_shift <= n_shift;
            r_poll  <= n_poll;
            r_scl   <= n_scl;
            r_sda   <= n_sda;
            r_ack   <= n_ack;
            r_fail  <= n_fail;
            r_rx    <= n_rx;
        end
    end

    always_comb begin
        o_result.scl_release     = n_scl;
        o_result.sda_release     = n_sda;
        o_result.busy_res        = (n_state != S_IDLE);
        o_result.done_res        = done;
        o_result.rx_byte         = n_rx;
        o_result.ack_fail        = n_fail;
        o_result.command_ignored = ignored;
    end

endmodule

// ===== design/i2cm_out_reg.sv =====
module i2cm_out_reg
    import i2cm_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_load,
    input  t_out_word i_word,
    input  logic      i_out_ready,
    output logic      o_can_load,
    output logic      o_out_valid,
    output t_out_word o_out_word
);

    logic      r_valid;
    t_out_word r_word;

    // slot is free when empty or being drained this cycle
    assign o_can_load = !r_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_can_load) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_word <= i_word;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_word  = r_word;

endmodule

// ===== design/i2c_master_byte_controller.sv =====
// Byte-level I2C master, paced by tick words.
// Input channel (i_in_valid / o_in_ready / i_in_word): each word is either a
// time tick (kind = 0, carries the sampled SDA level) or a command (kind = 1:
// start, stop, write byte, wait ack, read byte). Commands are taken only while
// idle; one arriving while busy, or with an unknown code, is dropped and
// flagged in command_ignored.
// Output channel (o_out_valid / i_out_ready / o_out_word): exactly one result
// word per input word, carrying SCL/SDA release levels, busy, done, the last
// received byte and the ack-fail flag.
// The result is registered, valid in the cycle after the word is accepted.
// Throughput: one word per clock while results are taken; the sequencer state
// updates at accept and the result lands in a single output register.
// Stall: when the receiver holds i_out_ready low with a result pending,
// o_in_ready drops and the result is held; ready returns in the cycle the
// result is taken, so no bubble is inserted.
// Config port (i_cfg_we / i_cfg_addr / i_cfg_data): write only, one register per
// cycle, meant for use while idle.
// Reset (i_rst_n, synchronous, active low): sequencer idle, both lines
// released, registers at their defaults, output register empty.
module i2c_master_byte_controller
    import i2cm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  t_in_word          i_in_word,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output t_out_word         o_out_word,
    input  logic              i_cfg_we,
    input  logic [CFG_AW-1:0] i_cfg_addr,
    input  logic [CFG_DW-1:0] i_cfg_data
);

    t_cfg      cfg;
    t_out_word seq_result;
    logic      can_load;
    logic      accept;

    assign o_in_ready = can_load;
    assign accept     = i_in_valid && can_load;

    i2cm_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    // sequencer: phase state, counters and line levels step on each accepted word
    i2cm_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_word   (i_in_word),
        .i_cfg    (cfg),
        .o_result (seq_result)
    );

    // result register decouples the two sides
    i2cm_out_reg u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (accept),
        .i_word      (seq_result),
        .i_out_ready (i_out_ready),
        .o_can_load  (can_load),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word)
    );

endmodule

// ===== design/i2c_master_byte_controller_chk.sv =====
module i2c_master_byte_controller_chk
    import i2cm_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      o_in_ready,
    input  logic      o_out_valid,
    input  logic      i_out_ready,
    input  t_out_word o_out_word
);

    // a stalled result stays put
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_word))
        else $error("result changed while stalled");

    // an empty output slot never blocks the input
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input blocked with empty output");

    // each accepted word yields a result next cycle
    a_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> o_out_valid)
        else $error("accepted word gave no result");

    // a finishing command leaves the block idle, and a dropped one finishes nothing
    a_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.done_res |->
            !o_out_word.busy_res && !o_out_word.command_ignored)
        else $error("done with busy or ignored");

endmodule

bind i2c_master_byte_controller i2c_master_byte_controller_chk u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_word  (o_out_word)
);

// ===== tb/i2c_master_byte_controller_tb.sv =====
`timescale 1ns / 1ps

module i2c_master_byte_controller_tb;
    import i2cm_pkg::*;

    // command codes the block must drop
    localparam logic [2:0] CMD_UNUSED_MIN = 3'd5;
    localparam logic [2:0] CMD_UNUSED_MAX = 3'd7;
    localparam int         CYCLE_LIMIT    = 500000;

    // sequencer phases of the bus model
    typedef enum logic [4:0] {
        PH_IDLE, PH_START_A, PH_START_B, PH_STOP_A, PH_STOP_B,
        PH_BIT_SETUP, PH_BIT_HIGH, PH_BIT_LOW,
        PH_ACKW_SETUP, PH_ACKW_HIGH, PH_ACKW_POLL,
        PH_RD_LOW, PH_RD_HIGH, PH_ACKR_SETUP, PH_ACKR_HIGH
    } t_phase;

    // one line of the directed table: a word, how often to send it, and an
    // optional hand-written expectation
    typedef struct packed {
        t_in_word   w;
        logic [15:0] reps;
        logic        pinned_exp;
        t_out_word   want;
    } t_row;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              in_valid = 1'b0;
    t_in_word          in_word = '0;
    logic              out_ready = 1'b1;
    logic              cfg_we = 1'b0;
    logic [CFG_AW-1:0] cfg_addr = '0;
    logic [CFG_DW-1:0] cfg_data = '0;
    logic              o_in_ready;
    logic              o_out_valid;
    t_out_word         o_out_word;

    i2c_master_byte_controller dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_word  (o_out_word),
        .i_cfg_we    (cfg_we),
        .i_cfg_addr  (cfg_addr),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Bus model: tracks the sequencer and line levels word by word
    // ------------------------------------------------------------------
    t_cfg        m_cfg;
    t_phase      m_phase;
    logic [7:0]  m_hold;
    logic [3:0]  m_bits;
    logic [7:0]  m_shift;
    logic [9:0]  m_polls;
    logic        m_scl, m_sda, m_ack_drive, m_fail;
    logic [7:0]  m_rx;

    t_out_word   expected_bus_q [$];
    int          mismatches = 0;
    int          n_checked = 0;
    int          n_sent = 0;
    int          n_finished = 0;
    int          n_dropped = 0;
    int          n_timeouts = 0;
    int          n_phases = 0;
    int          busy_words = 0;   // words that did real work in the random part
    int          cycle_cnt = 0;
    bit          calm_tail = 1'b0; // no gaps or stalls near the end
    int          stall_left = 0;

    function automatic void model_reset();
        m_cfg       = '{RST_START_STOP, RST_BIT_PHASE, RST_SHORT, RST_ACK_TMO};
        m_phase     = PH_IDLE;
        m_hold      = '0;
        m_bits      = '0;
        m_shift     = '0;
        m_polls     = '0;
        m_scl       = 1'b1;
        m_sda       = 1'b1;
        m_ack_drive = 1'b0;
        m_fail      = 1'b0;
        m_rx        = '0;
    endfunction

    function automatic void enter_phase(t_phase p, logic [7:0] ticks);
        m_phase = p;
        m_hold  = ticks;
    endfunction

    function automatic void begin_stop_cond();
        m_scl = 1'b0;
        m_sda = 1'b0;
        enter_phase(PH_STOP_A, m_cfg.start_stop_ticks);
    endfunction

    function automatic void shift_out_bit();
        m_sda   = m_shift[7];
        m_shift = m_shift << 1;
        enter_phase(PH_BIT_SETUP, m_cfg.bit_phase_ticks);
    endfunction

    // phase has run out of ticks; returns 1 when the command completes
    function automatic logic close_phase(logic sda);
        logic fin;
        fin = 1'b0;
        case (m_phase)
            PH_START_A: begin
                m_sda = 1'b0;
                enter_phase(PH_START_B, m_cfg.start_stop_ticks);
            end
            PH_START_B: begin
                m_scl   = 1'b0;
                m_phase = PH_IDLE;
                fin     = 1'b1;
            end
            PH_STOP_A: begin
                m_scl = 1'b1;
                m_sda = 1'b1;
                enter_phase(PH_STOP_B, m_cfg.start_stop_ticks);
            end
            PH_STOP_B: begin
                m_phase = PH_IDLE;
                fin     = 1'b1;
            end
            PH_BIT_SETUP: begin
                m_scl = 1'b1;
                enter_phase(PH_BIT_HIGH, m_cfg.bit_phase_ticks);
            end
            PH_BIT_HIGH: begin
                m_scl = 1'b0;
                enter_phase(PH_BIT_LOW, m_cfg.bit_phase_ticks);
            end
            PH_BIT_LOW: begin
                m_bits = m_bits + 4'd1;
                if (m_bits >= BITS_PER_BYTE) begin
                    m_phase = PH_IDLE;
                    fin     = 1'b1;
                end else begin
                    shift_out_bit();
                end
            end
            PH_ACKW_SETUP: begin
                m_scl = 1'b1;
                enter_phase(PH_ACKW_HIGH, m_cfg.short_ticks);
            end
            PH_ACKW_HIGH: begin
                m_phase = PH_ACKW_POLL;
                m_polls = '0;
            end
            PH_RD_LOW: begin
                // data bit is taken on the tick that raises SCL
                m_scl   = 1'b1;
                m_shift = {m_shift[6:0], sda};
                enter_phase(PH_RD_HIGH, m_cfg.short_ticks);
            end
            PH_RD_HIGH: begin
                m_scl  = 1'b0;
                m_bits = m_bits + 4'd1;
                if (m_bits >= BITS_PER_BYTE) begin
                    m_rx  = m_shift;
                    m_sda = ~m_ack_drive;
                    enter_phase(PH_ACKR_SETUP, m_cfg.bit_phase_ticks);
                end else begin
                    enter_phase(PH_RD_LOW, m_cfg.bit_phase_ticks);
                end
            end
            PH_ACKR_SETUP: begin
                m_scl = 1'b1;
                enter_phase(PH_ACKR_HIGH, m_cfg.bit_phase_ticks);
            end
            PH_ACKR_HIGH: begin
                m_scl   = 1'b0;
                m_phase = PH_IDLE;
                fin     = 1'b1;
            end
            default: m_phase = PH_IDLE;
        endcase
        return fin;
    endfunction

    function automatic logic run_tick(logic sda);
        if (m_phase == PH_IDLE)
            return 1'b0;
        if (m_phase == PH_ACKW_POLL) begin
            if (!sda) begin
                m_scl   = 1'b0;
                m_fail  = 1'b0;
                m_phase = PH_IDLE;
                return 1'b1;
            end
            // timeout: fails on the high sample after ack_timeout polls
            if (m_polls >= m_cfg.ack_timeout) begin
                m_fail = 1'b1;
                n_timeouts++;
                begin_stop_cond();
            end else begin
                m_polls = m_polls + 10'd1;
            end
            return 1'b0;
        end
        // a hold count of 0 behaves like 1
        if (m_hold > 8'd1) begin
            m_hold = m_hold - 8'd1;
            return 1'b0;
        end
        return close_phase(sda);
    endfunction

    function automatic void launch_cmd(t_in_word w);
        case (w.command)
            CMD_START: begin
                m_scl = 1'b1;
                m_sda = 1'b1;
                enter_phase(PH_START_A, m_cfg.start_stop_ticks);
            end
            CMD_STOP: begin_stop_cond();
            CMD_WRITE: begin
                m_scl   = 1'b0;
                m_bits  = '0;
                m_shift = w.tx_byte;
                shift_out_bit();
            end
            CMD_WAIT_ACK: begin
                m_fail = 1'b0;
                m_sda  = 1'b1;
                enter_phase(PH_ACKW_SETUP, m_cfg.short_ticks);
            end
            default: begin
                m_scl       = 1'b0;
                m_sda       = 1'b1;
                m_bits      = '0;
                m_shift     = '0;
                m_ack_drive = w.send_ack;
                enter_phase(PH_RD_LOW, m_cfg.bit_phase_ticks);
            end
        endcase
    endfunction

    function automatic t_out_word bus_model_step(t_in_word w);
        t_out_word r;
        logic      fin;
        logic      dropped;
        fin     = 1'b0;
        dropped = 1'b0;
        if (w.kind) begin
            // busy or unknown code: dropped, sequence untouched
            if (m_phase != PH_IDLE || w.command > CMD_READ)
                dropped = 1'b1;
            else
                launch_cmd(w);
        end else begin
            fin = run_tick(w.sda_in);
        end
        r.scl_release     = m_scl;
        r.sda_release     = m_sda;
        r.busy_res        = (m_phase != PH_IDLE);
        r.done_res        = fin;
        r.rx_byte         = m_rx;
        r.ack_fail        = m_fail;
        r.command_ignored = dropped;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------
    task automatic flag_mismatch(string what, int got, int want);
        mismatches++;
        $display("[%0t] mismatch %s: got 0x%0h, want 0x%0h", $time, what, got, want);
    endtask

    task automatic check_word(t_out_word got, t_out_word want);
        if (got.scl_release !== want.scl_release)
            flag_mismatch("scl_release", 32'(got.scl_release), 32'(want.scl_release));
        if (got.sda_release !== want.sda_release)
            flag_mismatch("sda_release", 32'(got.sda_release), 32'(want.sda_release));
        if (got.busy_res !== want.busy_res)
            flag_mismatch("busy_res", 32'(got.busy_res), 32'(want.busy_res));
        if (got.done_res !== want.done_res)
            flag_mismatch("done_res", 32'(got.done_res), 32'(want.done_res));
        if (got.rx_byte !== want.rx_byte)
            flag_mismatch("rx_byte", 32'(got.rx_byte), 32'(want.rx_byte));
        if (got.ack_fail !== want.ack_fail)
            flag_mismatch("ack_fail", 32'(got.ack_fail), 32'(want.ack_fail));
        if (got.command_ignored !== want.command_ignored)
            flag_mismatch("command_ignored", 32'(got.command_ignored),
                          32'(want.command_ignored));
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && out_ready) begin
            if (expected_bus_q.size() == 0) begin
                flag_mismatch("result word with nothing pending", 32'(o_out_word), 0);
            end else begin
                check_word(o_out_word, expected_bus_q.pop_front());
                n_checked++;
            end
        end
    end

    // receiver: random stall bursts
    always @(negedge i_clk) begin
        if (calm_tail) begin
            out_ready <= 1'b1;
        end else if (stall_left != 0) begin
            out_ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 7) == 0) begin
            out_ready  <= 1'b0;
            stall_left <= $urandom_range(0, 9);
        end else begin
            out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words pending", cycle_cnt,
                     expected_bus_q.size());
            $display("** i2c_master_byte_controller: FAILED **");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    // Valid is raised at a falling edge and left high after the accept;
    // the next call either replaces the word or drops valid.
    task automatic send_word(t_in_word w, bit pinned_exp = 1'b0, t_out_word want = '0);
        t_out_word pred;
        if (!calm_tail && $urandom_range(0, 7) == 0) begin
            repeat ($urandom_range(1, 10)) begin
                @(negedge i_clk);
                in_valid <= 1'b0;
            end
        end
        @(negedge i_clk);
        in_valid <= 1'b1;
        in_word  <= w;
        do @(posedge i_clk); while (!o_in_ready);
        pred = bus_model_step(w);
        expected_bus_q.push_back(pinned_exp ? want : pred);
        n_sent++;
        if (pred.done_res)
            n_finished++;
        if (pred.command_ignored)
            n_dropped++;
    endtask

    // run out the current sequence, then wait for every result word
    task automatic settle_sequence();
        t_in_word w;
        while (m_phase != PH_IDLE) begin
            w        = $bits(t_in_word)'($urandom);
            w.kind   = 1'b0;
            w.sda_in = 1'b0;
            send_word(w);
        end
        @(negedge i_clk);
        in_valid <= 1'b0;
        while (expected_bus_q.size() != 0)
            @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_cfg(t_cfg c);
        m_cfg = c;
        @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_addr <= REG_START_STOP;
        cfg_data <= CFG_DW'(c.start_stop_ticks);
        @(negedge i_clk);
        cfg_addr <= REG_BIT_PHASE;
        cfg_data <= CFG_DW'(c.bit_phase_ticks);
        @(negedge i_clk);
        cfg_addr <= REG_SHORT;
        cfg_data <= CFG_DW'(c.short_ticks);
        @(negedge i_clk);
        cfg_addr <= REG_ACK_TMO;
        cfg_data <= c.ack_timeout;
        @(negedge i_clk);
        cfg_we <= 1'b0;
    endtask

    function automatic t_row cmd_row(logic [2:0] code, logic [7:0] tx, logic ack);
        t_row r;
        r           = '0;
        r.w.kind    = 1'b1;
        r.w.command = code;
        r.w.tx_byte = tx;
        r.w.send_ack = ack;
        r.w.sda_in  = ~ack;
        r.reps      = 16'd1;
        return r;
    endfunction

    function automatic t_row tick_row(logic sda, int n);
        t_row r;
        r           = '0;
        r.w.sda_in  = sda;
        r.w.tx_byte = {8{sda}};
        r.reps      = 16'(n);
        return r;
    endfunction

    function automatic t_row pin(t_row r, t_out_word want);
        r.pinned_exp = 1'b1;
        r.want       = want;
        return r;
    endfunction

    task automatic play_rows(t_row rows [$]);
        foreach (rows[i])
            repeat (rows[i].reps)
                send_word(rows[i].w, rows[i].pinned_exp, rows[i].want);
    endtask

    // mostly short phases, now and then a longer one
    function automatic logic [7:0] pick_ticks();
        int r;
        r = $urandom_range(0, 19);
        if (r < 16)
            return 8'($urandom_range(1, 3));
        if (r < 19)
            return 8'($urandom_range(4, 8));
        return 8'($urandom_range(9, 24));
    endfunction

    // Well-formed traffic: a command whenever idle, ticks while busy, with
    // a few dropped commands, idle ticks and unknown codes mixed in.
    task automatic random_phase(int n_words);
        t_cfg     c;
        t_in_word w;
        int       ack_low_pct;
        int       roll;
        c.start_stop_ticks = pick_ticks();
        c.bit_phase_ticks  = pick_ticks();
        c.short_ticks      = pick_ticks();
        c.ack_timeout      = ($urandom_range(0, 4) == 0) ? 10'($urandom_range(1, 1023))
                                                         : 10'($urandom_range(1, 12));
        write_cfg(c);
        ack_low_pct = $urandom_range(5, 60);
        n_phases++;
        repeat (n_words) begin
            w    = $bits(t_in_word)'($urandom);
            roll = $urandom_range(0, 99);
            if (m_phase == PH_IDLE) begin
                w.kind = 1'b1;
                if (roll < 85) begin
                    w.command = 3'($urandom_range(CMD_START, CMD_READ));
                    busy_words++;
                end else if (roll < 93) begin
                    w.kind = 1'b0;
                end else begin
                    w.command = 3'($urandom_range(CMD_UNUSED_MIN, CMD_UNUSED_MAX));
                end
            end else if (roll < 4) begin
                w.kind = 1'b1;     // arrives while busy, any code
            end else begin
                w.kind = 1'b0;
                if (m_phase == PH_ACKW_POLL)
                    w.sda_in = ($urandom_range(0, 99) >= ack_low_pct);
                busy_words++;
            end
            send_word(w);
        end
        settle_sequence();
    endtask

    localparam t_out_word OUT_IDLE    = '{1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0};
    localparam t_out_word OUT_UNKNOWN = '{1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0, 1'b1};
    localparam t_out_word OUT_STARTED = '{1'b1, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0};
    localparam t_out_word OUT_BUSY_DROP = '{1'b1, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0, 1'b1};

    initial begin
        t_row     rows_reset_cfg [$];
        t_row     rows_min_cfg [$];
        t_in_word w;
        int       hold_ticks;

        model_reset();
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // at reset settings: idle tick, unknown codes, start, command while busy
        rows_reset_cfg.push_back(pin(tick_row(1'b1, 1), OUT_IDLE));
        rows_reset_cfg.push_back(pin(cmd_row(CMD_UNUSED_MAX, 8'hFF, 1'b1), OUT_UNKNOWN));
        rows_reset_cfg.push_back(pin(cmd_row(CMD_UNUSED_MIN, 8'h00, 1'b0), OUT_UNKNOWN));
        rows_reset_cfg.push_back(pin(cmd_row(CMD_START, 8'h5A, 1'b0), OUT_STARTED));
        rows_reset_cfg.push_back(pin(cmd_row(CMD_READ, 8'hA5, 1'b1), OUT_BUSY_DROP));
        rows_reset_cfg.push_back(tick_row(1'b1, 8));
        play_rows(rows_reset_cfg);
        settle_sequence();

        // every register at 1: one tick per phase, ack fails on
        // the second high poll
        write_cfg('{8'd1, 8'd1, 8'd1, 10'd1});
        rows_min_cfg.push_back(cmd_row(CMD_WRITE, 8'hFF, 1'b0));
        rows_min_cfg.push_back(tick_row(1'b0, 24));
        rows_min_cfg.push_back(cmd_row(CMD_WRITE, 8'h00, 1'b1));
        rows_min_cfg.push_back(tick_row(1'b1, 24));
        rows_min_cfg.push_back(cmd_row(CMD_WAIT_ACK, 8'h00, 1'b0));
        rows_min_cfg.push_back(tick_row(1'b1, 6));
        rows_min_cfg.push_back(cmd_row(CMD_WAIT_ACK, 8'hFF, 1'b1));
        rows_min_cfg.push_back(tick_row(1'b0, 3));
        rows_min_cfg.push_back(cmd_row(CMD_READ, 8'h00, 1'b1));
        rows_min_cfg.push_back(tick_row(1'b1, 18));
        rows_min_cfg.push_back(cmd_row(CMD_READ, 8'hFF, 1'b0));
        rows_min_cfg.push_back(tick_row(1'b0, 18));
        rows_min_cfg.push_back(cmd_row(CMD_STOP, 8'h00, 1'b0));
        rows_min_cfg.push_back(tick_row(1'b0, 2));
        rows_min_cfg.push_back(tick_row(1'b0, 1));
        play_rows(rows_min_cfg);
        settle_sequence();

        while (busy_words < 250)
            random_phase($urandom_range(60, 140));

        // every register at its maximum; a long ack wait keeps the run short
        write_cfg('{8'd255, 8'd255, 8'd255, 10'd1023});
        w         = $bits(t_in_word)'($urandom);
        w.kind    = 1'b1;
        w.command = CMD_WAIT_ACK;
        send_word(w);
        hold_ticks = $urandom_range(515, 560);
        for (int i = 0; i < hold_ticks; i++) begin
            w        = $bits(t_in_word)'($urandom);
            w.kind   = (i == 100);  // one command dropped mid-sequence
            w.sda_in = 1'b1;
            send_word(w);
        end
        settle_sequence();

        // back-to-back traffic to close the run
        calm_tail = 1'b1;
        random_phase(150);
        repeat (5) @(posedge i_clk);

        $display("%0d input words, %0d result words checked, %0d random setting phases",
                 n_sent, n_checked, n_phases);
        $display("%0d commands finished, %0d dropped, %0d ack waits timed out",
                 n_finished, n_dropped, n_timeouts);
        if (mismatches == 0 && expected_bus_q.size() == 0)
            $display("** i2c_master_byte_controller: PASSED **");
        else
            $display("** i2c_master_byte_controller: FAILED **");
        $finish;
    end

endmodule
